>>> design/xtv_pkg.sv
// ----------------------------------------------------------------------------
// xtv_pkg
// Shared types and constants for the XML tag value extractor.
// ----------------------------------------------------------------------------
package xtv_pkg;

  localparam int MAX_TAG   = 32;
  localparam int VAL_MAX   = 128;
  localparam int ROW_BYTES = 8;
  localparam int VAL_ROWS  = VAL_MAX / ROW_BYTES;
  localparam int ROW_W     = $clog2(VAL_ROWS);
  localparam int VCNT_W    = $clog2(VAL_MAX + 1);
  localparam int TCNT_W    = $clog2(MAX_TAG + 2);
  localparam int TIDX_W    = $clog2(MAX_TAG);
  localparam int TAG_WORDS = MAX_TAG / ROW_BYTES;
  localparam int WORD_W    = ROW_BYTES * 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0]  CH_LT       = 8'h3C;
  localparam logic [7:0]  CH_GT       = 8'h3E;
  localparam logic [7:0]  CH_SP       = 8'h20;
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;

  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TAG_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_MID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_UPPER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd5;

  localparam logic ST_FOUND = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_in;
  } in_t;

  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] chunk;
    logic [3:0]        chunk_bytes;
    logic              last;
  } out_t;

  typedef struct packed {
    logic              status;
    logic [VCNT_W-1:0] count;
    logic [WORD_W-1:0] tail;
  } req_t;

  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

endpackage

>>> design/xtv_ram.sv
// ----------------------------------------------------------------------------
// xtv_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module xtv_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/xtv_parser.sv
// ----------------------------------------------------------------------------
// xtv_parser
// Tag matcher, value capture and idle timer; holds the config registers.
// ----------------------------------------------------------------------------
module xtv_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  xtv_pkg::in_t                 item,
  input  logic                         cfg_wr,
  input  logic [xtv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xtv_pkg::WORD_W-1:0]   cfg_data,
  output xtv_pkg::ram_wr_t             ram_wr,
  output logic                         req_valid,
  output xtv_pkg::req_t                req
);

  logic [xtv_pkg::WORD_W-1:0] tag_chars [xtv_pkg::TAG_WORDS];
  logic [5:0]  tag_length;
  logic [15:0] timeout_ticks;

  logic                        in_tag, in_tag_next;
  logic                        in_value, in_value_next;
  logic [xtv_pkg::TCNT_W-1:0]  tag_count, tag_count_next;
  logic                        tag_mismatch, tag_mismatch_next;
  logic [xtv_pkg::VCNT_W-1:0]  value_count, value_count_next;
  logic [15:0]                 idle_ticks, idle_ticks_next;
  logic [xtv_pkg::WORD_W-1:0]  row_buf, row_buf_next;

  logic [5:0]                  len;
  logic [xtv_pkg::TIDX_W-1:0]  tidx;
  logic [7:0]                  tchar;
  logic [15:0]                 idle_inc;
  logic                        restart;
  logic [7:0]                  c;

  assign c     = item.char_in;
  assign len   = (tag_length > 6'(xtv_pkg::MAX_TAG)) ? 6'(xtv_pkg::MAX_TAG) : tag_length;
  assign tidx  = tag_count[xtv_pkg::TIDX_W-1:0];
  assign tchar = tag_chars[tidx[xtv_pkg::TIDX_W-1:3]][{tidx[2:0], 3'b000} +: 8];
  assign idle_inc = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;

  always_comb begin
    in_tag_next       = in_tag;
    in_value_next     = in_value;
    tag_count_next    = tag_count;
    tag_mismatch_next = tag_mismatch;
    value_count_next  = value_count;
    idle_ticks_next   = idle_ticks;
    row_buf_next      = row_buf;
    restart           = 1'b0;
    ram_wr            = '0;
    req_valid         = 1'b0;
    req.status        = xtv_pkg::ST_FOUND;
    req.count         = value_count;
    req.tail          = row_buf;
    if (take) begin
      case (item.op)
        xtv_pkg::OP_TICK: begin
          if (idle_inc > timeout_ticks) begin
            req_valid  = 1'b1;
            req.status = xtv_pkg::ST_EMPTY;
            req.count  = '0;
            restart    = 1'b1;
          end else begin
            idle_ticks_next = idle_inc;
          end
        end
        xtv_pkg::OP_CLOSE: begin
          req_valid  = 1'b1;
          req.status = xtv_pkg::ST_EMPTY;
          req.count  = '0;
          restart    = 1'b1;
        end
        xtv_pkg::OP_CHAR: begin
          idle_ticks_next = '0;
          if (c == xtv_pkg::CH_LT) begin
            if (in_value) begin
              req_valid = 1'b1;
              restart   = 1'b1;
            end else begin
              in_tag_next       = 1'b1;
              tag_count_next    = '0;
              tag_mismatch_next = 1'b0;
              value_count_next  = '0;
            end
          end else if (c == xtv_pkg::CH_GT) begin
            if (!tag_mismatch && tag_count == len) begin
              in_value_next = 1'b1;
            end
            in_tag_next = 1'b0;
          end else begin
            if (in_tag) begin
              if (c == xtv_pkg::CH_SP || tag_count > len) begin
                in_tag_next = 1'b0;
              end else begin
                if (tag_count >= len || tchar != c) begin
                  tag_mismatch_next = 1'b1;
                end
                tag_count_next = tag_count + 1'b1;
              end
            end
            if (in_value) begin
              if (value_count < xtv_pkg::VCNT_W'(xtv_pkg::VAL_MAX)) begin
                row_buf_next[{value_count[2:0], 3'b000} +: 8] = c;
                value_count_next = value_count + 1'b1;
                if (value_count[2:0] == 3'b111) begin
                  ram_wr.en   = 1'b1;
                  ram_wr.addr = xtv_pkg::ROW_W'(value_count >> 3);
                  ram_wr.data = row_buf_next;
                end
              end else begin
                in_value_next     = 1'b0;
                value_count_next  = '0;
                tag_mismatch_next = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (restart) begin
      in_tag_next       = 1'b0;
      in_value_next     = 1'b0;
      tag_count_next    = '0;
      tag_mismatch_next = 1'b0;
      value_count_next  = '0;
      idle_ticks_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_tag       <= 1'b0;
      in_value     <= 1'b0;
      tag_count    <= '0;
      tag_mismatch <= 1'b0;
      value_count  <= '0;
      idle_ticks   <= '0;
    end else begin
      in_tag       <= in_tag_next;
      in_value     <= in_value_next;
      tag_count    <= tag_count_next;
      tag_mismatch <= tag_mismatch_next;
      value_count  <= value_count_next;
      idle_ticks   <= idle_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    row_buf <= row_buf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_chars     <= '{default: '0};
      tag_length    <= '0;
      timeout_ticks <= xtv_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        xtv_pkg::REG_TAG_LOW:   tag_chars[0]  <= cfg_data;
        xtv_pkg::REG_TAG_MID:   tag_chars[1]  <= cfg_data;
        xtv_pkg::REG_TAG_UPPER: tag_chars[2]  <= cfg_data;
        xtv_pkg::REG_TAG_TOP:   tag_chars[3]  <= cfg_data;
        xtv_pkg::REG_TAG_LEN:   tag_length    <= cfg_data[5:0];
        xtv_pkg::REG_TIMEOUT:   timeout_ticks <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/xtv_emitter.sv
// ----------------------------------------------------------------------------
// xtv_emitter
// Result sequencer: reads stored rows and drives the output register.
// ----------------------------------------------------------------------------
module xtv_emitter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  xtv_pkg::req_t               req,
  output logic                        busy,
  output logic                        rd_en,
  output logic [xtv_pkg::ROW_W-1:0]   rd_addr,
  input  logic [xtv_pkg::WORD_W-1:0]  rd_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output xtv_pkg::out_t               out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_LD   = 2'd2;

  logic [1:0]                  state;
  logic                        job_valid;
  xtv_pkg::req_t               job;
  logic [xtv_pkg::ROW_W-1:0]   k;

  logic                        out_free;
  logic [xtv_pkg::VCNT_W-1:0]  full_rows;
  logic [xtv_pkg::VCNT_W-1:0]  last_k;
  logic                        is_full;
  logic                        is_last;
  logic [xtv_pkg::WORD_W-1:0]  tail_masked;
  xtv_pkg::out_t               ld_word;
  xtv_pkg::out_t               empty_word;

  assign busy      = job_valid;
  assign out_free  = !out_valid || !out_stall;
  assign full_rows = job.count >> 3;
  assign last_k    = (job.count - 1'b1) >> 3;
  assign is_full   = xtv_pkg::VCNT_W'(k) < full_rows;
  assign is_last   = xtv_pkg::VCNT_W'(k) == last_k;
  assign rd_en     = (state == S_RD);
  assign rd_addr   = k;

  always_comb begin
    tail_masked = '0;
    for (int b = 0; b < xtv_pkg::ROW_BYTES; b++) begin
      if (3'(b) < job.count[2:0]) begin
        tail_masked[b*8 +: 8] = job.tail[b*8 +: 8];
      end
    end
  end

  always_comb begin
    ld_word.status      = job.status;
    ld_word.chunk       = is_full ? rd_data : tail_masked;
    ld_word.chunk_bytes = is_full ? 4'(xtv_pkg::ROW_BYTES) : {1'b0, job.count[2:0]};
    ld_word.last        = is_last;
    empty_word.status      = job.status;
    empty_word.chunk       = '0;
    empty_word.chunk_bytes = '0;
    empty_word.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            job       <= req;
            job_valid <= 1'b1;
          end else if (job_valid) begin
            if (job.count == '0) begin
              if (out_free) begin
                out_data  <= empty_word;
                out_valid <= 1'b1;
                job_valid <= 1'b0;
              end
            end else begin
              k     <= '0;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          if (out_free) begin
            out_data  <= ld_word;
            out_valid <= 1'b1;
            if (is_last) begin
              job_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rd_then_ld: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |=> state == S_LD)
    else $error("row read not followed by load");

  a_busy_job: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> job_valid)
    else $error("sequencer active without a job");

  a_req_free: assert property (@(posedge clk) disable iff (rst)
    req_valid |-> !job_valid)
    else $error("result request while a job is pending");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == xtv_pkg::ST_EMPTY |->
      out_data.chunk_bytes == 4'd0 && out_data.last)
    else $error("empty result carries data");

  a_next_chunk: assert property (@(posedge clk) disable iff (rst)
    state == S_LD && out_free && !is_last |=>
      state == S_RD && k == xtv_pkg::ROW_W'($past(k) + 1'b1))
    else $error("chunk index did not advance");

endmodule

>>> design/xml_tag_value_extractor.sv
// ----------------------------------------------------------------------------
// xml_tag_value_extractor
// Finds a configured XML tag in a character stream and returns its value
// as packed 8-byte chunks.
//
//   channel | dir | handshake          | word
//   in      | in  | in_valid/in_stall  | op, char_in
//   out     | out | out_valid/out_stall| status, chunk, chunk_bytes, last
//   cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One input word per cycle while scanning.
// An empty result is latched as a job, then loaded into the output register;
// a value of n chars is latched, then sent as ceil(n/8) chunks (row read, load).
// Input stalls until the last chunk sits in the output register.
// Synchronous reset, no clearing pass; value RAM contents are don't-care.
// Output stall freezes the sequencer at the load step.
// ----------------------------------------------------------------------------
module xml_tag_value_extractor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  xtv_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output xtv_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [xtv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xtv_pkg::WORD_W-1:0]    cfg_data
);

  logic                        take;
  logic                        busy;
  xtv_pkg::ram_wr_t            ram_wr;
  logic                        req_valid;
  xtv_pkg::req_t               req;
  logic                        rd_en;
  logic [xtv_pkg::ROW_W-1:0]   rd_addr;
  logic [xtv_pkg::WORD_W-1:0]  rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign take      = in_valid && !busy;

  xtv_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_wr    (ram_wr),
    .req_valid (req_valid),
    .req       (req)
  );

  xtv_ram #(
    .DEPTH (xtv_pkg::VAL_ROWS),
    .WIDTH (xtv_pkg::WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  xtv_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sim/xtv_checker.sv
// ----------------------------------------------------------------------------
// xtv_checker
// Watches the input, output and register channels of the tag value
// extractor and tracks its own copy of the parser and registers. Each
// accepted input word updates that copy. Any chunk it produces is queued,
// and each accepted output word is compared field by field with the
// oldest queued chunk.
// ----------------------------------------------------------------------------
module xtv_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  xtv_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  xtv_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [xtv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xtv_pkg::WORD_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            outstanding,
  output int                            results_seen,
  output int                            words_seen
);
  import xtv_pkg::*;

  localparam int VIDX_W = $clog2(VAL_MAX);

  logic [WORD_W-1:0] tag_word [TAG_WORDS];
  logic [5:0]        tag_len_reg;
  logic [15:0]       idle_limit;

  logic              in_tag;
  logic              in_value;
  logic              name_bad;
  int unsigned       name_count;
  int unsigned       value_count;
  logic [15:0]       idle_ticks;
  logic [7:0]        value_buf [VAL_MAX];

  out_t              pending_chunks [$];
  int                errs;
  int                n_results;
  int                n_words;

  task automatic restart_scan();
    in_tag      = 1'b0;
    in_value    = 1'b0;
    name_bad    = 1'b0;
    name_count  = 0;
    value_count = 0;
    idle_ticks  = '0;
  endtask

  function automatic logic [7:0] target_char(int unsigned i);
    logic [4:0] p;
    p = i[4:0];
    return tag_word[p[4:3]][p[2:0]*8 +: 8];
  endfunction

  task automatic push_empty();
    out_t r;
    r        = '0;
    r.status = ST_EMPTY;
    r.last   = 1'b1;
    pending_chunks.push_back(r);
    restart_scan();
  endtask

  task automatic push_value();
    out_t r;
    int   nchunks;
    nchunks = (value_count + 7) / ROW_BYTES;
    if (nchunks == 0) nchunks = 1;
    for (int k = 0; k < nchunks; k++) begin
      r        = '0;
      r.status = ST_FOUND;
      for (int b = 0; b < ROW_BYTES; b++) begin
        if (k * ROW_BYTES + b < value_count) begin
          r.chunk[b*8 +: 8] = value_buf[VIDX_W'(k*ROW_BYTES + b)];
          r.chunk_bytes     = r.chunk_bytes + 4'd1;
        end
      end
      r.last = (k == nchunks - 1);
      pending_chunks.push_back(r);
    end
    restart_scan();
  endtask

  task automatic scan_char(logic [7:0] c, int unsigned len);
    idle_ticks = '0;
    if (c == CH_LT) begin
      if (in_value) begin
        push_value();
      end else begin
        in_tag      = 1'b1;
        name_count  = 0;
        name_bad    = 1'b0;
        value_count = 0;
      end
    end else if (c == CH_GT) begin
      if (!name_bad && name_count == len) in_value = 1'b1;
      in_tag = 1'b0;
    end else begin
      if (in_tag) begin
        if (c == CH_SP) begin
          in_tag = 1'b0;
        end else if (name_count > len) begin
          in_tag = 1'b0;
        end else begin
          if (name_count >= len || target_char(name_count) != c) name_bad = 1'b1;
          name_count++;
        end
      end
      if (in_value) begin
        if (value_count < VAL_MAX) begin
          value_buf[VIDX_W'(value_count)] = c;
          value_count++;
        end else begin
          // overlong value: dropped, and this tag cannot match again
          in_value    = 1'b0;
          value_count = 0;
          name_bad    = 1'b1;
        end
      end
    end
  endtask

  task automatic scan_word(in_t w);
    int unsigned len;
    len = (tag_len_reg > MAX_TAG) ? MAX_TAG : tag_len_reg;
    case (w.op)
      OP_TICK: begin
        if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
        if (idle_ticks > idle_limit) push_empty();
      end
      OP_CLOSE: push_empty();
      OP_CHAR:  scan_char(w.char_in, len);
      default: ;
    endcase
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] d);
    case (idx)
      REG_TAG_LOW:   tag_word[0] = d;
      REG_TAG_MID:   tag_word[1] = d;
      REG_TAG_UPPER: tag_word[2] = d;
      REG_TAG_TOP:   tag_word[3] = d;
      REG_TAG_LEN:   tag_len_reg = d[5:0];
      REG_TIMEOUT:   idle_limit  = d[15:0];
      default: ;
    endcase
  endtask

  task automatic note_fail(string why, out_t e, out_t a);
    errs++;
    if (errs <= 10) begin
      $display("%0t %s: status %0b/%0b chunk %h/%h bytes %0d/%0d last %0b/%0b (exp/got)",
               $time, why, e.status, a.status, e.chunk, a.chunk,
               e.chunk_bytes, a.chunk_bytes, e.last, a.last);
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      tag_word    = '{default: '0};
      tag_len_reg = '0;
      idle_limit  = TIMEOUT_RST;
      restart_scan();
      pending_chunks.delete();
      errs      = 0;
      n_results = 0;
      n_words   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_words++;
        if (out_data.last) n_results++;
        if (pending_chunks.size() == 0) begin
          note_fail("unexpected word", '0, out_data);
        end else begin
          e = pending_chunks.pop_front();
          if (e.status !== out_data.status || e.chunk !== out_data.chunk ||
              e.chunk_bytes !== out_data.chunk_bytes || e.last !== out_data.last)
            note_fail("mismatch", e, out_data);
        end
      end
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) scan_word(in_data);
    end
    fail_count   <= errs;
    outstanding  <= pending_chunks.size();
    results_seen <= n_results;
    words_seen   <= n_words;
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the tag value extractor bench. Starts with a short directed run
// (default registers, a target built of extreme bytes, an empty value,
// timeout, close, the unused op and the spare register slots). Then come
// random phases, each with fresh registers: well-formed tags with random
// values up to and past the size limit, wrong names, noise, ticks and
// closes. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb;
  import xtv_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [1:0]           OP_NONE      = 2'd3;
  localparam int                   NIDX_W       = $clog2(MAX_TAG);
  localparam int                   WORD_TARGET  = 380;

  typedef enum int {PACE_NONE, PACE_ANY, PACE_SOME} pace_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data  = '0;

  int    fail_count, outstanding, results_seen, words_seen;
  pace_t in_mode  = PACE_NONE;
  pace_t out_mode = PACE_NONE;
  int    words_sent    = 0;
  int    settings_done = 0;
  logic [7:0] name_chars [MAX_TAG];
  int    name_len = 0;

  always #4 clk = ~clk;

  xml_tag_value_extractor uut (.*);
  xtv_checker xtv_check (.*);

  function automatic int draw_wait(pace_t mode);
    case (mode)
      PACE_NONE: return 0;
      PACE_ANY:  return $urandom_range(0, 12);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // tag name byte: anything but the delimiters
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do c = rand_byte(); while (c == CH_LT || c == CH_GT || c == CH_SP);
    return c;
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    do c = rand_byte(); while (c == CH_LT);
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] name_word(int k);
    logic [WORD_W-1:0] w;
    for (int b = 0; b < ROW_BYTES; b++)
      w[b*8 +: 8] = name_chars[NIDX_W'(k*ROW_BYTES + b)];
    return w;
  endfunction

  task automatic send_word(logic [1:0] op, logic [7:0] ch);
    int gap;
    gap = draw_wait(in_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, char_in: ch};
    do @(posedge clk); while (in_stall);
    if (op != OP_NONE) words_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    send_word(OP_CHAR, c);
  endtask

  // leaves cfg_valid high; the caller drops it after its last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic new_setting();
    logic [5:0]        len_field;
    logic [15:0]       tmo;
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 9))
      0:       len_field = 6'd0;
      1:       len_field = 6'd1;
      2:       len_field = 6'(MAX_TAG);
      3:       len_field = 6'($urandom_range(MAX_TAG + 1, 63));
      default: len_field = 6'($urandom_range(2, 10));
    endcase
    case ($urandom_range(0, 9))
      0:       tmo = 16'd0;
      1:       tmo = 16'd1;
      2:       tmo = 16'hFFFF;
      3:       tmo = TIMEOUT_RST;
      default: tmo = 16'($urandom_range(2, 8));
    endcase
    for (int i = 0; i < MAX_TAG; i++) name_chars[NIDX_W'(i)] = name_char();
    name_len = (len_field > MAX_TAG) ? MAX_TAG : int'(len_field);
    write_reg(REG_TAG_LOW, name_word(0));
    write_reg(REG_TAG_MID, name_word(1));
    write_reg(REG_TAG_UPPER, name_word(2));
    write_reg(REG_TAG_TOP, name_word(3));
    // junk above the field width must be ignored
    w = {$urandom, $urandom};
    w[5:0] = len_field;
    write_reg(REG_TAG_LEN, w);
    w = {$urandom, $urandom};
    w[15:0] = tmo;
    write_reg(REG_TIMEOUT, w);
    cfg_valid <= 1'b0;
    in_mode  = pace_t'($urandom_range(0, 2));
    out_mode = pace_t'($urandom_range(0, 2));
    settings_done++;
  endtask

  task automatic send_ticks();
    repeat ($urandom_range(1, 8)) send_word(OP_TICK, rand_byte());
  endtask

  task automatic send_value();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 10)      n = 0;
    else if (r < 85) n = $urandom_range(1, 16);
    else if (r < 95) n = $urandom_range(17, VAL_MAX);
    else             n = $urandom_range(VAL_MAX + 1, VAL_MAX + 7);
    repeat (n) send_char(value_char());
  endtask

  task automatic send_segment();
    int kind, n;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      send_char(CH_LT);
      for (int i = 0; i < name_len; i++) send_char(name_chars[NIDX_W'(i)]);
      if ($urandom_range(0, 3) == 0) begin
        send_char(CH_SP);
        n = $urandom_range(0, 6);
        repeat (n) send_char(name_char());
      end
      send_char(CH_GT);
      send_value();
      case ($urandom_range(0, 9))
        0:       send_word(OP_CLOSE, rand_byte());
        1:       send_ticks();
        default: send_char(CH_LT);
      endcase
    end else if (kind < 65) begin
      // near miss: mostly the target name with stray bytes, 0 to name_len+3 long
      send_char(CH_LT);
      n = $urandom_range(0, name_len + 3);
      for (int i = 0; i < n; i++)
        send_char(($urandom_range(0, 2) == 0) ? name_char() : name_chars[NIDX_W'(i)]);
      send_char(CH_GT);
      send_value();
      send_char(CH_LT);
    end else if (kind < 78) begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 5))
          0:       send_char(CH_LT);
          1:       send_char(CH_GT);
          2:       send_char(CH_SP);
          default: send_char(rand_byte());
        endcase
      end
    end else if (kind < 88) begin
      send_ticks();
    end else if (kind < 94) begin
      send_word(OP_CLOSE, rand_byte());
    end else begin
      send_word(OP_NONE, rand_byte());
    end
  endtask

  initial begin : out_pacing
    int hold;
    wait (!rst);
    forever begin
      hold = draw_wait(out_mode);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at reset: empty target name, so "<>" opens a value
    send_char(CH_LT);
    send_char(CH_GT);
    send_char("v");
    send_char(CH_LT);
    settle();

    write_reg(REG_TAG_LOW, 64'hFFFF_FFFF_FF01_FF61);
    write_reg(REG_TAG_MID, '1);
    write_reg(REG_TAG_UPPER, '0);
    write_reg(REG_TAG_TOP, 64'hA5A5_5A5A_0F0F_F0F0);
    write_reg(REG_TAG_LEN, 64'd3);
    write_reg(REG_TIMEOUT, 64'd2);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 64'h5555_AAAA_5555_AAAA);
    cfg_valid <= 1'b0;
    settings_done++;
    out_mode = PACE_ANY;

    // value of extreme bytes, then an empty value
    send_char(CH_LT);
    send_char("a");
    send_char(8'hFF);
    send_char(8'h01);
    send_char(CH_GT);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_LT);
    send_char(CH_LT);
    send_char("a");
    send_char(8'hFF);
    send_char(8'h01);
    send_char(CH_GT);
    send_char(CH_LT);
    send_word(OP_NONE, 8'hFF);
    // third tick passes the limit of two
    send_word(OP_TICK, 8'h00);
    send_word(OP_TICK, 8'h7F);
    send_word(OP_TICK, 8'h80);
    send_word(OP_CLOSE, 8'hAA);

    while (words_sent < WORD_TARGET) begin
      settle();
      new_setting();
      repeat ($urandom_range(4, 12)) begin
        if (words_sent < WORD_TARGET) send_segment();
      end
    end
    settle();

    repeat (40) @(posedge clk);
    $display("Sent %0d input words across %0d register settings.", words_sent, settings_done);
    $display("Compared %0d results (%0d output words), %0d still awaited.",
             results_seen, words_seen, outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("Run did not finish in time.");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
design/xtv_pkg.sv
design/xtv_ram.sv
design/xtv_parser.sv
design/xtv_emitter.sv
design/xml_tag_value_extractor.sv
sim/xtv_checker.sv
sim/tb.sv
